// ===== hw/rtl/data_group_deframer_reassembler_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the data-group deframer
// Small wrappers for the concurrent checks used in the RTL.
// ---------------------------------------------------------------------------
`ifndef DATA_GROUP_DEFRAMER_REASSEMBLER_ASSERT_SVH
`define DATA_GROUP_DEFRAMER_REASSEMBLER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define DGDR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define DGDR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/dgdr_pkg.sv =====
// ---------------------------------------------------------------------------
// dgdr_pkg
// Constants, types and the CRC byte step for the data-group deframer.
// ---------------------------------------------------------------------------
package dgdr_pkg;

  localparam int DATAGRAM_DEPTH = 8192;
  localparam int ADDR_W         = $clog2(DATAGRAM_DEPTH);
  localparam int LEN_W          = ADDR_W + 1;
  localparam int POS_CAP        = DATAGRAM_DEPTH + 64;
  localparam int WP_CAP         = DATAGRAM_DEPTH + 3;

  localparam logic       OP_PUSH       = 1'b0;
  localparam logic       OP_READ       = 1'b1;
  localparam logic       KIND_STATUS   = 1'b0;
  localparam logic       KIND_READ     = 1'b1;
  localparam logic [3:0] CONT_MASK     = 4'b1111;
  localparam logic [7:0] SEG_NUM_MASKB = 8'b01111111;
  localparam logic [7:0] LAST_SEG_BIT  = 8'b10000000;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_INCOMPLETE = 3'd1,
    ST_BAD_CRC    = 3'd2,
    ST_SEG_LOST   = 3'd3,
    ST_OVERFLOW   = 3'd4,
    ST_SHORT      = 3'd5
  } status_t;

  typedef struct packed {
    logic seg;
    logic valid;
    logic start;
  } mode_t;

  // CRC-16-CCITT, polynomial 0x1021, MSB first, one byte per call.
  function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/dgdr_ram.sv =====
// ---------------------------------------------------------------------------
// dgdr_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module dgdr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/data_group_deframer_reassembler.sv =====
// ---------------------------------------------------------------------------
// data_group_deframer_reassembler
// Parses data-group bytes, checks CRC, continuity and segment order, and
// assembles datagrams in an on-chip store that read transfers fetch from.
// ---------------------------------------------------------------------------
//
//  Channel | Direction | Ports
//  --------+-----------+----------------------------------------------------
//  in      | input     | in_valid/in_ready, opcode, group_byte, group_end,
//          |           | read_index
//  out     | output    | out_valid/out_ready, result_kind, status,
//          |           | datagram_length, read_data, missing_groups,
//          |           | assembly_valid
//
// A new input transfer is taken in each cycle while the output register is free
// or being emptied in that same cycle.
// Header parsing, the CRC step and the group judgement are done in the cycle
// of the input transfer; a push writes the datagram RAM in that cycle.
// A read is issued to the RAM on its input transfer, and the RAM's registered
// data drive read_data directly, gated by the result kind in the output register.
// Reset is synchronous and active low; the RAM needs no clearing pass, since
// only bytes below the committed length are ever returned.
// A stalled result holds the output register, and with it the input side.
// ---------------------------------------------------------------------------
`include "data_group_deframer_reassembler_assert.svh"

module data_group_deframer_reassembler (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_opcode,
  input  logic [7:0]  in_group_byte,
  input  logic        in_group_end,
  input  logic [12:0] in_read_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_result_kind,
  output logic [2:0]  out_status,
  output logic [13:0] out_datagram_length,
  output logic [7:0]  out_read_data,
  output logic [3:0]  out_missing_groups,
  output logic        out_assembly_valid
);

  localparam int LW = dgdr_pkg::LEN_W;
  localparam int AW = dgdr_pkg::ADDR_W;

  // Per-group and persistent state held in flip-flops.
  logic [LW-1:0]  committed_r, committed_nxt;
  logic [LW-1:0]  wp_r, wp_nxt;
  logic [LW-1:0]  pos_r, pos_nxt;
  logic [7:0]     flags_r, flags_nxt;
  logic [5:0]     hep_r, hep_nxt;
  logic [15:0]    crc_r, crc_nxt;
  logic [15:0]    trail_r, trail_nxt;
  logic [15:0]    segf_r, segf_nxt;
  logic [14:0]    prev_seg_r, prev_seg_nxt;
  logic [4:0]     prev_cont_r, prev_cont_nxt;
  logic [3:0]     gap_r, gap_nxt;
  logic [3:0]     held_cont_r, held_cont_nxt;
  dgdr_pkg::mode_t mode_r, mode_nxt;

  // Output register.
  logic        out_valid_r, out_valid_nxt;
  logic        out_kind_r, out_kind_nxt;
  logic [2:0]  out_status_r, out_status_nxt;
  logic [LW-1:0] out_len_r, out_len_nxt;
  logic [3:0]  out_miss_r, out_miss_nxt;
  logic        out_av_r, out_av_nxt;
  logic        out_inrange_r, out_inrange_nxt;

  // RAM port signals.
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic          ram_re;
  logic [7:0]    ram_q;

  logic accept;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  dgdr_ram #(
    .WIDTH(8),
    .DEPTH(dgdr_pkg::DATAGRAM_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(in_group_byte),
    .re   (ram_re),
    .raddr(AW'(in_read_index)),
    .rdata(ram_q)
  );

  always_comb begin
    logic [7:0]    f;
    logic [5:0]    segpos;
    logic [5:0]    uapos;
    logic [5:0]    hep_n;
    logic [15:0]   segf_n;
    logic [LW-1:0] wp_n;
    logic [LW-1:0] pos_i;
    logic          fresh;
    logic [LW-1:0] base;
    logic [6:0]    need;
    logic [14:0]   num;
    logic [14:0]   expect_num;
    logic [LW:0]   total;
    logic          done;
    logic [3:0]    gap_n;
    dgdr_pkg::mode_t m;
    dgdr_pkg::status_t st;

    committed_nxt = committed_r;
    wp_nxt        = wp_r;
    pos_nxt       = pos_r;
    flags_nxt     = flags_r;
    hep_nxt       = hep_r;
    crc_nxt       = crc_r;
    trail_nxt     = trail_r;
    segf_nxt      = segf_r;
    prev_seg_nxt  = prev_seg_r;
    prev_cont_nxt = prev_cont_r;
    gap_nxt       = gap_r;
    held_cont_nxt = held_cont_r;
    mode_nxt      = mode_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_waddr     = AW'(wp_r);

    out_valid_nxt   = out_valid_r && !out_ready;
    out_kind_nxt    = out_kind_r;
    out_status_nxt  = out_status_r;
    out_len_nxt     = out_len_r;
    out_miss_nxt    = out_miss_r;
    out_av_nxt      = out_av_r;
    out_inrange_nxt = out_inrange_r;

    f = (pos_r == '0) ? in_group_byte : flags_r;
    segpos = f[7] ? 6'd4 : 6'd2;
    uapos  = segpos + (f[5] ? 6'd2 : 6'd0);
    if (pos_r == '0) begin
      hep_n = uapos + {5'd0, in_group_byte[4]};
    end else if (f[4] && (pos_r == LW'(uapos))) begin
      hep_n = hep_r + {2'd0, in_group_byte[3:0]};
    end else begin
      hep_n = hep_r;
    end
    segf_n = segf_r;
    if (f[5] && (pos_r == LW'(segpos))) begin
      segf_n = {in_group_byte, segf_r[7:0]};
    end
    if (f[5] && (pos_r == LW'(segpos + 6'd1))) begin
      segf_n = {segf_r[15:8], in_group_byte};
    end
    // A group starts a new datagram unless it continues a segment run upwards.
    fresh = mode_r.start || !f[5] ||
            ((segf_n[14:0] & {dgdr_pkg::SEG_NUM_MASKB[6:0], 8'hFF}) <= prev_seg_r);
    base = fresh ? '0 : committed_r;
    pos_i = (32'(pos_r) < dgdr_pkg::POS_CAP) ? pos_r + LW'(1) : pos_r;
    wp_n = wp_r;
    if (pos_r >= LW'(hep_n)) begin
      if (pos_r == LW'(hep_n)) begin
        wp_n = base;
      end
    end

    // Judgement defaults.
    need  = {1'b0, hep_n} + (f[6] ? 7'd2 : 7'd0);
    num   = segf_n[14:0];
    expect_num = fresh ? 15'd0 : prev_seg_r + 15'd1;
    total = '0;
    gap_n = gap_r;
    done  = 1'b0;
    m     = mode_r;
    st    = dgdr_pkg::ST_OK;

    if (accept && (in_opcode == dgdr_pkg::OP_READ)) begin
      ram_re          = 1'b1;
      out_valid_nxt   = 1'b1;
      out_kind_nxt    = dgdr_pkg::KIND_READ;
      out_status_nxt  = dgdr_pkg::ST_OK;
      out_len_nxt     = committed_r;
      out_miss_nxt    = gap_r;
      out_av_nxt      = mode_r.valid;
      out_inrange_nxt = (32'(in_read_index) < 32'(committed_r)) &&
                        (32'(in_read_index) < dgdr_pkg::DATAGRAM_DEPTH);
    end else if (accept) begin
      flags_nxt = f;
      hep_nxt   = hep_n;
      segf_nxt  = segf_n;
      if (pos_r == LW'(1)) begin
        held_cont_nxt = in_group_byte[7:4];
      end
      if (pos_r >= LW'(2)) begin
        crc_nxt = dgdr_pkg::crc_byte(crc_r, trail_r[15:8]);
      end
      trail_nxt = {trail_r[7:0], in_group_byte};
      if (pos_r >= LW'(hep_n)) begin
        ram_we    = (32'(wp_n) < dgdr_pkg::DATAGRAM_DEPTH);
        ram_waddr = AW'(wp_n);
        wp_n = (32'(wp_n) < dgdr_pkg::WP_CAP) ? wp_n + LW'(1) : wp_n;
      end
      wp_nxt  = wp_n;
      pos_nxt = pos_i;

      if (in_group_end) begin
        if ({{(LW-7){1'b0}}, need} > pos_i) begin
          m.valid = 1'b0;
          committed_nxt = '0;
          st = dgdr_pkg::ST_SHORT;
          done = 1'b1;
        end
        if (!done) begin
          if (m.start) begin
            m.valid = 1'b1;
          end
          if (f[6] && ((crc_nxt ^ 16'hFFFF) != trail_nxt)) begin
            m.valid = 1'b0;
            committed_nxt = '0;
            st = dgdr_pkg::ST_BAD_CRC;
            done = 1'b1;
          end
        end
        if (!done) begin
          if (f[5]) begin
            if (fresh && !m.start) begin
              m.valid = 1'b1;
            end
            if (segf_n[15] == dgdr_pkg::LAST_SEG_BIT[7]) begin
              m.seg   = 1'b0;
              m.start = 1'b1;
              prev_seg_nxt = '0;
            end else begin
              m.seg = 1'b1;
              if (num != expect_num) begin
                m.valid = 1'b0;
                committed_nxt = base;
                st = dgdr_pkg::ST_SEG_LOST;
                done = 1'b1;
              end else begin
                prev_seg_nxt = num;
                m.start = 1'b0;
              end
            end
          end else begin
            m.seg   = 1'b0;
            m.start = 1'b1;
            m.valid = 1'b1;
          end
        end
        if (!done) begin
          gap_n = prev_cont_r[4] ? 4'd1 : ((held_cont_nxt - prev_cont_r[3:0]) &
                                           dgdr_pkg::CONT_MASK);
          gap_nxt = gap_n;
          prev_cont_nxt = {1'b0, held_cont_nxt};
          if (gap_n != 4'd1) begin
            m.valid = 1'b0;
            committed_nxt = base;
            st = dgdr_pkg::ST_SEG_LOST;
            done = 1'b1;
          end
        end
        if (!done) begin
          total = {1'b0, base} + ({1'b0, pos_i} - (LW+1)'(need));
          if (32'(total) > dgdr_pkg::DATAGRAM_DEPTH) begin
            m = '{seg: 1'b0, valid: 1'b0, start: 1'b1};
            prev_seg_nxt = '0;
            committed_nxt = '0;
            st = dgdr_pkg::ST_OVERFLOW;
          end else begin
            committed_nxt = LW'(total);
            if (m.seg) begin
              st = m.valid ? dgdr_pkg::ST_INCOMPLETE : dgdr_pkg::ST_SEG_LOST;
            end
          end
        end
        mode_nxt = m;

        // Clear the per-group parse state for the next group.
        wp_nxt        = '0;
        pos_nxt       = '0;
        flags_nxt     = '0;
        hep_nxt       = 6'd2;
        crc_nxt       = 16'hFFFF;
        trail_nxt     = '0;
        segf_nxt      = '0;
        held_cont_nxt = '0;

        out_valid_nxt   = 1'b1;
        out_kind_nxt    = dgdr_pkg::KIND_STATUS;
        out_status_nxt  = st;
        out_len_nxt     = committed_nxt;
        out_miss_nxt    = gap_nxt;
        out_av_nxt      = m.valid;
        out_inrange_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      committed_r <= '0;
      wp_r        <= '0;
      pos_r       <= '0;
      flags_r     <= '0;
      hep_r       <= 6'd2;
      crc_r       <= 16'hFFFF;
      trail_r     <= '0;
      segf_r      <= '0;
      prev_seg_r  <= '0;
      prev_cont_r <= 5'b10000;
      gap_r       <= 4'd1;
      held_cont_r <= '0;
      mode_r      <= '{seg: 1'b0, valid: 1'b1, start: 1'b1};
      out_valid_r <= 1'b0;
    end else begin
      committed_r <= committed_nxt;
      wp_r        <= wp_nxt;
      pos_r       <= pos_nxt;
      flags_r     <= flags_nxt;
      hep_r       <= hep_nxt;
      crc_r       <= crc_nxt;
      trail_r     <= trail_nxt;
      segf_r      <= segf_nxt;
      prev_seg_r  <= prev_seg_nxt;
      prev_cont_r <= prev_cont_nxt;
      gap_r       <= gap_nxt;
      held_cont_r <= held_cont_nxt;
      mode_r      <= mode_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_kind_r    <= out_kind_nxt;
    out_status_r  <= out_status_nxt;
    out_len_r     <= out_len_nxt;
    out_miss_r    <= out_miss_nxt;
    out_av_r      <= out_av_nxt;
    out_inrange_r <= out_inrange_nxt;
  end

  // The RAM read data stay put until the next read, which can only be taken
  // once this result leaves.
  assign out_valid           = out_valid_r;
  assign out_result_kind     = out_kind_r;
  assign out_status          = out_status_r;
  assign out_datagram_length = 14'(out_len_r);
  assign out_read_data       = (out_kind_r == dgdr_pkg::KIND_READ && out_inrange_r) ?
                               ram_q : 8'd0;
  assign out_missing_groups  = out_miss_r;
  assign out_assembly_valid  = out_av_r;

  `DGDR_ASSERT_IMP(a_wp_cap, clk, rst_n, 1'b1, 32'(wp_r) <= dgdr_pkg::WP_CAP, "write pointer past cap")
  `DGDR_ASSERT_IMP(a_pos_cap, clk, rst_n, 1'b1, 32'(pos_r) <= dgdr_pkg::POS_CAP, "byte position past cap")
  `DGDR_ASSERT_IMP(a_read_status, clk, rst_n, out_valid_r && out_kind_r == dgdr_pkg::KIND_READ, out_status_r == dgdr_pkg::ST_OK, "read result with status")
  `DGDR_ASSERT_IMP(a_len_range, clk, rst_n, 1'b1, 32'(committed_r) <= dgdr_pkg::DATAGRAM_DEPTH, "committed length above store")
  `DGDR_ASSERT_NXT(a_stall_hold, clk, rst_n, out_valid_r && !out_ready, out_valid_r && $stable(out_kind_r), "result dropped while stalled")

endmodule
